// ===== rtl/core/verlet_constraint_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Verlet constraint engine
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef VERLET_CONSTRAINT_ENGINE_CORE_ASSERT_SVH
`define VERLET_CONSTRAINT_ENGINE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define VCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// same-cycle implication
`define VCE_ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define VCE_ASSERT(lbl, clk, rst, prop, msg)
`define VCE_ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/core/vce_pkg.sv =====
// ----------------------------------------------------------------------------
// vce_pkg
// Shared types and constants of the Verlet constraint engine.
// ----------------------------------------------------------------------------
package vce_pkg;

   // field widths
   localparam int MODE_W      = 3;
   localparam int VIDX_W      = 8;
   localparam int COORD_W     = 32;
   localparam int ULEN_W      = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // internal arithmetic widths
   localparam int WIDE_W      = 50;
   localparam int MUL_W       = 35;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIFF_W      = 34;
   localparam int ABS_W       = 33;
   localparam int HALF_W      = 32;
   localparam int RADICAND_W  = 64;
   localparam int LEN_W       = 33;
   localparam int DIVIDEND_W  = ABS_W + 16;
   localparam int ROOT_W      = 32;
   localparam int QUOT_W      = 19;
   localparam int UNIT_W      = QUOT_W + 1;
   localparam int ITER_CNT_W  = 6;
   localparam int ROOT_STEPS  = 32;
   localparam int DIV_STEPS   = QUOT_W;

   // register reset values
   localparam logic signed [COORD_W-1:0] GRAVITY_RESET      = '0;
   localparam logic [ULEN_W-1:0]         STEP_SQUARED_RESET = 31'd65536;
   localparam logic [ULEN_W-1:0]         RIGHT_LIMIT_RESET  = 31'd52428800;
   localparam logic [ULEN_W-1:0]         BOTTOM_LIMIT_RESET = 31'd39321600;
   localparam logic [ULEN_W-1:0]         LOW_LIMIT_RESET    = 31'd72090;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE     = 3'd0,
      MODE_INTEGRATE = 3'd1,
      MODE_CLAMP     = 3'd2,
      MODE_RELAX     = 3'd3,
      MODE_READ      = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRAVITY_X    = 3'd0,
      CSR_GRAVITY_Y    = 3'd1,
      CSR_STEP_SQUARED = 3'd2,
      CSR_RIGHT_LIMIT  = 3'd3,
      CSR_BOTTOM_LIMIT = 3'd4,
      CSR_LOW_LIMIT    = 3'd5
   } csr_index_type;

   typedef enum logic {
      ITER_SQRT = 1'b0,
      ITER_DIV  = 1'b1
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

endpackage

// ===== rtl/core/vce_req_if.sv =====
// ----------------------------------------------------------------------------
// vce_req_if
// Request channel: one engine operation per transfer.
// ----------------------------------------------------------------------------
interface vce_req_if;
   import vce_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [VIDX_W-1:0]          vertex_a;
   logic [VIDX_W-1:0]          vertex_b;
   logic signed [COORD_W-1:0]  coord_x;
   logic signed [COORD_W-1:0]  coord_y;
   logic [ULEN_W-1:0]          rest_length;

   modport source (output valid, mode, vertex_a, vertex_b, coord_x, coord_y, rest_length,
                   input ready);
   modport sink   (input valid, mode, vertex_a, vertex_b, coord_x, coord_y, rest_length,
                   output ready);
endinterface

// ===== rtl/core/vce_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vce_rsp_if
// Response channel: vertex positions after each request.
// ----------------------------------------------------------------------------
interface vce_rsp_if;
   import vce_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] a_x;
   logic signed [COORD_W-1:0] a_y;
   logic signed [COORD_W-1:0] b_x;
   logic signed [COORD_W-1:0] b_y;
   logic                      status;

   modport source (output valid, a_x, a_y, b_x, b_y, status, input ready);
   modport sink   (input valid, a_x, a_y, b_x, b_y, status, output ready);
endinterface

// ===== rtl/core/vce_csr_if.sv =====
// ----------------------------------------------------------------------------
// vce_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface vce_csr_if;
   import vce_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vce_ram.sv =====
// ----------------------------------------------------------------------------
// vce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vce_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/vce_iter.sv =====
// ----------------------------------------------------------------------------
// vce_iter
// Shared bit-serial unit: integer square root (two radicand bits per step)
// and restoring division (one quotient bit per step) on one subtractor.
// ----------------------------------------------------------------------------
module vce_iter (
   input  logic                              clock,
   input  logic                              reset,
   input  vce_pkg::iter_cmd_type             cmd,
   input  logic [vce_pkg::RADICAND_W-1:0]    radicand,
   input  logic [vce_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [vce_pkg::LEN_W-1:0]         divisor,
   output vce_pkg::iter_stat_type            stat,
   output logic [vce_pkg::ROOT_W-1:0]        result
);
   import vce_pkg::*;

   iter_op_type             op_ff;
   logic [RADICAND_W-1:0]   acc_ff;
   logic [RADICAND_W-1:0]   res_ff;
   logic [RADICAND_W-1:0]   sub_ff;
   logic [ITER_CNT_W-1:0]   cnt_ff;
   logic                    done_ff;

   logic [RADICAND_W-1:0]   trial;
   logic [RADICAND_W-1:0]   rem;
   logic                    ge;

   // trial subtrahend: res+bit for the root, shifted divisor for division
   assign trial = (op_ff == ITER_SQRT) ? res_ff + sub_ff : sub_ff;
   assign ge    = acc_ff >= trial;
   assign rem   = acc_ff - trial;

   // step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == ITER_CNT_W'(1));
         if (cmd.start) begin
            cnt_ff <= (cmd.op == ITER_SQRT) ? ITER_CNT_W'(ROOT_STEPS)
                                            : ITER_CNT_W'(DIV_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - ITER_CNT_W'(1);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.op;
         res_ff <= '0;
         if (cmd.op == ITER_SQRT) begin
            acc_ff <= radicand;
            sub_ff <= RADICAND_W'(1) << (RADICAND_W - 2);
         end else begin
            acc_ff <= RADICAND_W'(dividend);
            sub_ff <= RADICAND_W'(divisor) << (DIV_STEPS - 1);
         end
      end else if (cnt_ff != '0) begin
         if (ge) begin
            acc_ff <= rem;
         end
         if (op_ff == ITER_SQRT) begin
            res_ff <= ge ? (res_ff >> 1) + sub_ff : res_ff >> 1;
            sub_ff <= sub_ff >> 2;
         end else begin
            res_ff <= {res_ff[RADICAND_W-2:0], ge};
            sub_ff <= sub_ff >> 1;
         end
      end
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign result    = res_ff[ROOT_W-1:0];
endmodule

// ===== rtl/core/verlet_constraint_engine_core.sv =====
// ----------------------------------------------------------------------------
// verlet_constraint_engine_core
// Particle store with Verlet integration, screen clamp and distance-constraint
// relaxation in signed Q16.16, run by a sequencer over one multiplier and a
// shared root/divide unit.
//
//   channel  dir  handshake     contents
//   req_     in   valid/ready   mode, vertex_a, vertex_b, coord_x/y, rest_length
//   rsp_     out  valid/ready   a_x, a_y, b_x, b_y, status
//   csr_     in   valid/ready   index, data (register write, always ready)
//
// One request at a time. A relax request runs a 32-step root and two 19-step
// divides in vce_iter, one bit per cycle, and a zero-length edge skips the
// divides; an index at or above VERTEX_COUNT is wrapped by repeated
// subtraction of VERTEX_COUNT before the request goes on.
// The response register frees the engine: the next request is taken while a
// response waits, and a finished request stalls only if one still waits.
// Synchronous reset clears control and CSRs; datapath and stores hold no reset.
// ----------------------------------------------------------------------------
`include "verlet_constraint_engine_core_assert.svh"

module verlet_constraint_engine_core #(
   parameter int VERTEX_COUNT = 256,
   parameter int COORD_WIDTH  = 32
) (
   input  logic      clock,
   input  logic      reset,
   vce_req_if.sink   req_port,
   vce_rsp_if.source rsp_port,
   vce_csr_if.sink   csr_port
);
   import vce_pkg::*;

   localparam int CW = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;
   localparam int IW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam logic [16:0] VC_L = 17'(VERTEX_COUNT);
   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

   typedef enum logic [27:0] {
      ST_IDLE   = 28'd1 << 0,
      ST_REDUCE = 28'd1 << 1,
      ST_WRITE  = 28'd1 << 2,
      ST_RDA    = 28'd1 << 3,
      ST_LDA    = 28'd1 << 4,
      ST_LDB    = 28'd1 << 5,
      ST_CLAMP  = 28'd1 << 6,
      ST_MULGX  = 28'd1 << 7,
      ST_MULGY  = 28'd1 << 8,
      ST_INTEG  = 28'd1 << 9,
      ST_DIFF   = 28'd1 << 10,
      ST_HALF   = 28'd1 << 11,
      ST_SQX    = 28'd1 << 12,
      ST_SQY    = 28'd1 << 13,
      ST_SUM    = 28'd1 << 14,
      ST_ROOTGO = 28'd1 << 15,
      ST_ROOTW  = 28'd1 << 16,
      ST_LENCHK = 28'd1 << 17,
      ST_DIVXGO = 28'd1 << 18,
      ST_DIVXW  = 28'd1 << 19,
      ST_DIVYGO = 28'd1 << 20,
      ST_DIVYW  = 28'd1 << 21,
      ST_CORRX  = 28'd1 << 22,
      ST_CORRY  = 28'd1 << 23,
      ST_UPD    = 28'd1 << 24,
      ST_WRA    = 28'd1 << 25,
      ST_WRB    = 28'd1 << 26,
      ST_FINISH = 28'd1 << 27
   } state_type;

   // saturate a wide value to the coordinate range
   function automatic logic signed [CW-1:0] sat_cw(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[CW-1:0];
   endfunction

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [CW-1:0] v);
      return WIDE_W'(v);
   endfunction

   // clamp one axis into [low, upper], low winning when they cross
   function automatic logic signed [CW-1:0] clamp_axis(input logic signed [CW-1:0] v,
                                                       input logic [ULEN_W-1:0] upper,
                                                       input logic [ULEN_W-1:0] low);
      logic signed [WIDE_W-1:0] t;
      logic signed [WIDE_W-1:0] up;
      logic signed [WIDE_W-1:0] lo;
      up = $signed(WIDE_W'(upper));
      lo = $signed(WIDE_W'(low));
      t  = widen(v);
      if (t > up) begin
         t = up;
      end
      if (t < lo) begin
         t = lo;
      end
      return sat_cw(t);
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic signed [COORD_W-1:0] grav_x_ff, grav_y_ff;
   logic [ULEN_W-1:0]         step_sq_ff, right_ff, bottom_ff, low_ff;

   // captured request
   logic [MODE_W-1:0]         mode_ff;
   logic [VIDX_W-1:0]         va_ff, vb_ff;
   logic signed [COORD_W-1:0] coord_x_ff, coord_y_ff;
   logic [ULEN_W-1:0]         rest_ff;

   // working registers
   logic signed [CW-1:0]      ax_ff, ay_ff, apx_ff, apy_ff, bx_ff, by_ff;
   logic signed [WIDE_W-1:0]  accx_ff, cx_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic [ABS_W-1:0]          adx_ff, ady_ff;
   logic [HALF_W-1:0]         hx_ff, hy_ff;
   logic                      sh_ff;
   logic [RADICAND_W-1:0]     sum_ff;
   logic [LEN_W-1:0]          len_ff;
   logic signed [MUL_W-1:0]   diff_ff;
   logic signed [UNIT_W-1:0]  ux_ff, uy_ff;
   logic signed [PROD_W-1:0]  prod_ff;

   // result and response registers
   logic signed [CW-1:0]      ra_x_ff, ra_y_ff, rb_x_ff, rb_y_ff;
   logic                      rstat_ff;
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_a_x_ff, rsp_a_y_ff, rsp_b_x_ff, rsp_b_y_ff;
   logic                      rsp_status_ff;

   // combinational helpers
   logic                      req_fire, rsp_load;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic                      mul_en;
   logic [IW-1:0]             raddr, waddr;
   logic                      we_pos, we_prev;
   logic [CW-1:0]             wd_pos_x, wd_pos_y, wd_prev_x, wd_prev_y;
   logic [CW-1:0]             rd_pos_x, rd_pos_y, rd_prev_x, rd_prev_y;
   logic signed [CW-1:0]      wr_x, wr_y, cl_x, cl_y, in_x, in_y;
   logic signed [WIDE_W-1:0]  accy, cy;
   logic [ABS_W-1:0]          abs_x, abs_y;
   logic                      need_half;
   logic                      a_wrap, b_wrap;
   logic [DIVIDEND_W-1:0]     div_num;
   iter_cmd_type              iter_cmd;
   iter_stat_type             iter_stat;
   logic [ROOT_W-1:0]         iter_result;

   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_port.ready);
   assign a_wrap   = 17'(va_ff) >= VC_L;
   assign b_wrap   = 17'(vb_ff) >= VC_L;

   // per-mode arithmetic
   assign wr_x  = sat_cw(WIDE_W'(coord_x_ff));
   assign wr_y  = sat_cw(WIDE_W'(coord_y_ff));
   assign cl_x  = clamp_axis(ax_ff, right_ff, low_ff);
   assign cl_y  = clamp_axis(ay_ff, bottom_ff, low_ff);
   assign accy  = WIDE_W'(prod_ff >>> 16);
   assign in_x  = sat_cw(widen(ax_ff) + widen(ax_ff) - widen(apx_ff) + accx_ff);
   assign in_y  = sat_cw(widen(ay_ff) + widen(ay_ff) - widen(apy_ff) + accy);
   assign cy    = WIDE_W'(prod_ff >>> 17);
   assign abs_x = dx_ff[DIFF_W-1] ? ABS_W'(-dx_ff) : ABS_W'(dx_ff);
   assign abs_y = dy_ff[DIFF_W-1] ? ABS_W'(-dy_ff) : ABS_W'(dy_ff);
   assign need_half = (abs_x[ABS_W-1:ABS_W-2] != '0) || (abs_y[ABS_W-1:ABS_W-2] != '0);

   // dividend of the active axis, taken by the divider at its start
   assign div_num = (state_ff == ST_DIVYGO) ? {ady_ff, 16'd0} : {adx_ff, 16'd0};

   // sequencer and shared-unit control
   always_comb begin
      state_in     = state_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      raddr        = IW'(va_ff);
      waddr        = IW'(va_ff);
      we_pos       = 1'b0;
      we_prev      = 1'b0;
      wd_pos_x     = ra_x_ff;
      wd_pos_y     = ra_y_ff;
      wd_prev_x    = ax_ff;
      wd_prev_y    = ay_ff;
      iter_cmd     = '{start: 1'b0, op: ITER_SQRT};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!a_wrap && !b_wrap) begin
               state_in = (mode_ff == MODE_WRITE) ? ST_WRITE : ST_RDA;
            end
         end
         ST_WRITE: begin
            we_pos    = 1'b1;
            we_prev   = 1'b1;
            wd_pos_x  = wr_x;
            wd_pos_y  = wr_y;
            wd_prev_x = wr_x;
            wd_prev_y = wr_y;
            state_in  = ST_FINISH;
         end
         ST_RDA: state_in = ST_LDA;
         ST_LDA: begin
            raddr    = IW'(vb_ff);
            state_in = ST_LDB;
         end
         ST_LDB: begin
            unique case (mode_ff)
               MODE_INTEGRATE: state_in = ST_MULGX;
               MODE_CLAMP:     state_in = ST_CLAMP;
               MODE_RELAX:     state_in = ST_DIFF;
               default:        state_in = ST_FINISH;
            endcase
         end
         ST_CLAMP: begin
            we_pos   = 1'b1;
            wd_pos_x = cl_x;
            wd_pos_y = cl_y;
            state_in = ST_FINISH;
         end
         ST_MULGX: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(grav_x_ff);
            mul_b    = MUL_W'(step_sq_ff);
            state_in = ST_MULGY;
         end
         ST_MULGY: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(grav_y_ff);
            mul_b    = MUL_W'(step_sq_ff);
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            we_pos   = 1'b1;
            we_prev  = 1'b1;
            wd_pos_x = in_x;
            wd_pos_y = in_y;
            state_in = ST_FINISH;
         end
         ST_DIFF: state_in = ST_HALF;
         ST_HALF: state_in = ST_SQX;
         ST_SQX: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(hx_ff);
            mul_b    = MUL_W'(hx_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(hy_ff);
            mul_b    = MUL_W'(hy_ff);
            state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_ROOTGO;
         ST_ROOTGO: begin
            iter_cmd = '{start: 1'b1, op: ITER_SQRT};
            state_in = ST_ROOTW;
         end
         ST_ROOTW: begin
            if (iter_stat.done) begin
               state_in = ST_LENCHK;
            end
         end
         ST_LENCHK: begin
            state_in = (len_ff == '0) ? ST_FINISH : ST_DIVXGO;
         end
         ST_DIVXGO: begin
            iter_cmd = '{start: 1'b1, op: ITER_DIV};
            state_in = ST_DIVXW;
         end
         ST_DIVXW: begin
            if (iter_stat.done) begin
               state_in = ST_DIVYGO;
            end
         end
         ST_DIVYGO: begin
            iter_cmd = '{start: 1'b1, op: ITER_DIV};
            state_in = ST_DIVYW;
         end
         ST_DIVYW: begin
            if (iter_stat.done) begin
               state_in = ST_CORRX;
            end
         end
         ST_CORRX: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(ux_ff);
            mul_b    = diff_ff;
            state_in = ST_CORRY;
         end
         ST_CORRY: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(uy_ff);
            mul_b    = diff_ff;
            state_in = ST_UPD;
         end
         ST_UPD: state_in = ST_WRA;
         ST_WRA: begin
            we_pos   = 1'b1;
            state_in = ST_WRB;
         end
         ST_WRB: begin
            we_pos   = 1'b1;
            waddr    = IW'(vb_ff);
            wd_pos_x = rb_x_ff;
            wd_pos_y = rb_y_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_x_ff  <= GRAVITY_RESET;
         grav_y_ff  <= GRAVITY_RESET;
         step_sq_ff <= STEP_SQUARED_RESET;
         right_ff   <= RIGHT_LIMIT_RESET;
         bottom_ff  <= BOTTOM_LIMIT_RESET;
         low_ff     <= LOW_LIMIT_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_GRAVITY_X:    grav_x_ff  <= $signed(csr_port.data);
            CSR_GRAVITY_Y:    grav_y_ff  <= $signed(csr_port.data);
            CSR_STEP_SQUARED: step_sq_ff <= csr_port.data[ULEN_W-1:0];
            CSR_RIGHT_LIMIT:  right_ff   <= csr_port.data[ULEN_W-1:0];
            CSR_BOTTOM_LIMIT: bottom_ff  <= csr_port.data[ULEN_W-1:0];
            CSR_LOW_LIMIT:    low_ff     <= csr_port.data[ULEN_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_port.mode;
         va_ff      <= req_port.vertex_a;
         vb_ff      <= req_port.vertex_b;
         coord_x_ff <= req_port.coord_x;
         coord_y_ff <= req_port.coord_y;
         rest_ff    <= req_port.rest_length;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (rsp_load) begin
         rsp_a_x_ff    <= COORD_W'(ra_x_ff);
         rsp_a_y_ff    <= COORD_W'(ra_y_ff);
         rsp_b_x_ff    <= COORD_W'(rb_x_ff);
         rsp_b_y_ff    <= COORD_W'(rb_y_ff);
         rsp_status_ff <= rstat_ff;
      end
      unique case (state_ff)
         ST_REDUCE: begin
            // wrap indices into the store one step at a time
            if (a_wrap) begin
               va_ff <= va_ff - VIDX_W'(VERTEX_COUNT);
            end
            if (b_wrap) begin
               vb_ff <= vb_ff - VIDX_W'(VERTEX_COUNT);
            end
         end
         ST_WRITE: begin
            ra_x_ff  <= wr_x;
            ra_y_ff  <= wr_y;
            rb_x_ff  <= '0;
            rb_y_ff  <= '0;
            rstat_ff <= 1'b0;
         end
         ST_LDA: begin
            ax_ff  <= rd_pos_x;
            ay_ff  <= rd_pos_y;
            apx_ff <= rd_prev_x;
            apy_ff <= rd_prev_y;
         end
         ST_LDB: begin
            bx_ff    <= rd_pos_x;
            by_ff    <= rd_pos_y;
            ra_x_ff  <= ax_ff;
            ra_y_ff  <= ay_ff;
            rb_x_ff  <= '0;
            rb_y_ff  <= '0;
            rstat_ff <= 1'b0;
         end
         ST_CLAMP: begin
            ra_x_ff <= cl_x;
            ra_y_ff <= cl_y;
         end
         ST_MULGY: accx_ff <= WIDE_W'(prod_ff >>> 16);
         ST_INTEG: begin
            ra_x_ff <= in_x;
            ra_y_ff <= in_y;
         end
         ST_DIFF: begin
            dx_ff <= DIFF_W'(widen(bx_ff) - widen(ax_ff));
            dy_ff <= DIFF_W'(widen(by_ff) - widen(ay_ff));
         end
         ST_HALF: begin
            // halve both axes when either is too wide to square in range
            adx_ff <= abs_x;
            ady_ff <= abs_y;
            sh_ff  <= need_half;
            hx_ff  <= HALF_W'(abs_x >> need_half);
            hy_ff  <= HALF_W'(abs_y >> need_half);
         end
         ST_SQY: sum_ff <= prod_ff[RADICAND_W-1:0];
         ST_SUM: sum_ff <= sum_ff + prod_ff[RADICAND_W-1:0];
         ST_ROOTW: begin
            if (iter_stat.done) begin
               len_ff <= LEN_W'(iter_result) << sh_ff;
            end
         end
         ST_LENCHK: begin
            // zero-length edge: report both ends unchanged
            diff_ff  <= $signed(MUL_W'(len_ff)) - $signed(MUL_W'(rest_ff));
            rb_x_ff  <= bx_ff;
            rb_y_ff  <= by_ff;
            rstat_ff <= (len_ff == '0);
         end
         ST_DIVXW: begin
            if (iter_stat.done) begin
               ux_ff <= dx_ff[DIFF_W-1] ? -UNIT_W'(iter_result[QUOT_W-1:0])
                                        :  UNIT_W'(iter_result[QUOT_W-1:0]);
            end
         end
         ST_DIVYW: begin
            if (iter_stat.done) begin
               uy_ff <= dy_ff[DIFF_W-1] ? -UNIT_W'(iter_result[QUOT_W-1:0])
                                        :  UNIT_W'(iter_result[QUOT_W-1:0]);
            end
         end
         ST_CORRY: cx_ff <= WIDE_W'(prod_ff >>> 17);
         ST_UPD: begin
            ra_x_ff <= sat_cw(widen(ax_ff) + cx_ff);
            ra_y_ff <= sat_cw(widen(ay_ff) + cy);
            rb_x_ff <= sat_cw(widen(bx_ff) - cx_ff);
            rb_y_ff <= sat_cw(widen(by_ff) - cy);
         end
         default: ;
      endcase
   end

   // vertex stores
   vce_ram #(.WIDTH(CW), .DEPTH(VERTEX_COUNT)) u_pos_x (
      .clock(clock), .we(we_pos), .waddr(waddr), .wdata(wd_pos_x),
      .raddr(raddr), .rdata(rd_pos_x)
   );
   vce_ram #(.WIDTH(CW), .DEPTH(VERTEX_COUNT)) u_pos_y (
      .clock(clock), .we(we_pos), .waddr(waddr), .wdata(wd_pos_y),
      .raddr(raddr), .rdata(rd_pos_y)
   );
   vce_ram #(.WIDTH(CW), .DEPTH(VERTEX_COUNT)) u_prev_x (
      .clock(clock), .we(we_prev), .waddr(waddr), .wdata(wd_prev_x),
      .raddr(raddr), .rdata(rd_prev_x)
   );
   vce_ram #(.WIDTH(CW), .DEPTH(VERTEX_COUNT)) u_prev_y (
      .clock(clock), .we(we_prev), .waddr(waddr), .wdata(wd_prev_y),
      .raddr(raddr), .rdata(rd_prev_y)
   );

   // shared root / divide unit
   vce_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (iter_cmd),
      .radicand (sum_ff),
      .dividend (div_num),
      .divisor  (len_ff),
      .stat     (iter_stat),
      .result   (iter_result)
   );

   // ports
   assign req_port.ready  = (state_ff == ST_IDLE);
   assign csr_port.ready  = 1'b1;
   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.a_x    = rsp_a_x_ff;
   assign rsp_port.a_y    = rsp_a_y_ff;
   assign rsp_port.b_x    = rsp_b_x_ff;
   assign rsp_port.b_y    = rsp_b_y_ff;
   assign rsp_port.status = rsp_status_ff;

   // checks
   `VCE_ASSERT_IMPLIES(a_idx_reduced, clock, reset, state_ff == ST_RDA, (17'(va_ff) < VC_L) && (17'(vb_ff) < VC_L), "vertex index not wrapped into store")
   `VCE_ASSERT_IMPLIES(a_iter_done_wait, clock, reset, iter_stat.done, (state_ff == ST_ROOTW) || (state_ff == ST_DIVXW) || (state_ff == ST_DIVYW), "iterative unit finished outside a wait state")
   `VCE_ASSERT_IMPLIES(a_wrb_order, clock, reset, state_ff == ST_WRB, $past(state_ff) == ST_WRA, "second edge end written without first")
   `VCE_ASSERT(a_stall_hold, clock, reset, (state_ff == ST_FINISH && rsp_valid_ff && !rsp_port.ready) |=> (state_ff == ST_FINISH), "result overwrote a pending response")
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Verlet constraint engine testbench
// Drives write, integrate, clamp, relax and read requests with random gaps
// and back-pressure. A scoreboard keeps its own vertex store and registers,
// predicts every response and checks each one in order. Register settings
// change between phases, including the extreme values.
// ----------------------------------------------------------------------------
module tb;
   import vce_pkg::*;

   localparam int VERTICES = 256;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
   localparam int DRAIN_CYCLES = 150;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 235;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [VIDX_W-1:0]  vertex_a;
      logic [VIDX_W-1:0]  vertex_b;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [ULEN_W-1:0]  rest_length;
   } engine_req_type;

   typedef struct {
      logic [COORD_W-1:0] a_x;
      logic [COORD_W-1:0] a_y;
      logic [COORD_W-1:0] b_x;
      logic [COORD_W-1:0] b_y;
      logic               status;
   } engine_rsp_type;

   // ------------------------------------------------------------------------
   // Scoreboard: vertex store, registers and queue of predicted responses
   // ------------------------------------------------------------------------
   class vertex_scoreboard;
      longint pos_x[VERTICES], pos_y[VERTICES], old_x[VERTICES], old_y[VERTICES];
      longint grav_x, grav_y, step_sq, right_lim, bottom_lim, low_lim;
      engine_rsp_type pending_rsp[$];
      int errors, checked, relaxed, skipped;

      function new();
         grav_x = 0;
         grav_y = 0;
         step_sq = STEP_SQUARED_RESET;
         right_lim = RIGHT_LIMIT_RESET;
         bottom_lim = BOTTOM_LIMIT_RESET;
         low_lim = LOW_LIMIT_RESET;
      endfunction

      function longint sat(longint v);
         return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
      endfunction

      function longint unsigned isqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function longint clamp_axis(longint v, longint upper);
         if (v > upper) v = upper;
         if (v < low_lim) v = low_lim;
         return sat(v);
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GRAVITY_X:    grav_x = longint'($signed(data));
            CSR_GRAVITY_Y:    grav_y = longint'($signed(data));
            CSR_STEP_SQUARED: step_sq = longint'(data[ULEN_W-1:0]);
            CSR_RIGHT_LIMIT:  right_lim = longint'(data[ULEN_W-1:0]);
            CSR_BOTTOM_LIMIT: bottom_lim = longint'(data[ULEN_W-1:0]);
            CSR_LOW_LIMIT:    low_lim = longint'(data[ULEN_W-1:0]);
            default: ;
         endcase
      endfunction

      // predict the response of one accepted request
      function void note(engine_req_type r);
         int a, b, s;
         longint px, py, dx, dy, adx, ady, len, diff, ux, uy, cx, cy, nbx, nby;
         longint unsigned hx, hy;
         engine_rsp_type e;
         a = r.vertex_a;
         b = r.vertex_b;
         e.status = 1'b0;
         e.b_x = '0;
         e.b_y = '0;
         case (r.mode)
            MODE_WRITE: begin
               pos_x[a] = longint'($signed(r.coord_x));
               pos_y[a] = longint'($signed(r.coord_y));
               old_x[a] = pos_x[a];
               old_y[a] = pos_y[a];
            end
            MODE_INTEGRATE: begin
               px = pos_x[a];
               py = pos_y[a];
               pos_x[a] = sat(px + (px - old_x[a]) + ((grav_x * step_sq) >>> 16));
               pos_y[a] = sat(py + (py - old_y[a]) + ((grav_y * step_sq) >>> 16));
               old_x[a] = px;
               old_y[a] = py;
            end
            MODE_CLAMP: begin
               pos_x[a] = clamp_axis(pos_x[a], right_lim);
               pos_y[a] = clamp_axis(pos_y[a], bottom_lim);
            end
            MODE_RELAX: begin
               dx = pos_x[b] - pos_x[a];
               dy = pos_y[b] - pos_y[a];
               adx = dx < 0 ? -dx : dx;
               ady = dy < 0 ? -dy : dy;
               // wide differences are halved before the root
               s = (adx >= 64'sd2147483648 || ady >= 64'sd2147483648) ? 1 : 0;
               hx = longint'(adx) >> s;
               hy = longint'(ady) >> s;
               len = longint'(isqrt(hx * hx + hy * hy) << s);
               relaxed++;
               if (len == 0) begin
                  e.status = 1'b1;
                  skipped++;
               end else begin
                  diff = len - longint'(r.rest_length);
                  ux = (dx * 65536) / len;
                  uy = (dy * 65536) / len;
                  cx = (ux * diff) >>> 17;
                  cy = (uy * diff) >>> 17;
                  nbx = sat(pos_x[b] - cx);
                  nby = sat(pos_y[b] - cy);
                  pos_x[a] = sat(pos_x[a] + cx);
                  pos_y[a] = sat(pos_y[a] + cy);
                  pos_x[b] = nbx;
                  pos_y[b] = nby;
               end
               e.b_x = pos_x[b][31:0];
               e.b_y = pos_y[b][31:0];
            end
            default: ;
         endcase
         e.a_x = pos_x[a][31:0];
         e.a_y = pos_y[a][31:0];
         pending_rsp = {pending_rsp, e};
      endfunction

      // compare one response with the oldest prediction
      function void check(engine_rsp_type got);
         engine_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected: a_x %h", $time, got.a_x);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         checked++;
         if (got.a_x !== e.a_x) begin
            $display("%0t: a_x expected %h actual %h", $time, e.a_x, got.a_x);
            errors++;
         end
         if (got.a_y !== e.a_y) begin
            $display("%0t: a_y expected %h actual %h", $time, e.a_y, got.a_y);
            errors++;
         end
         if (got.b_x !== e.b_x) begin
            $display("%0t: b_x expected %h actual %h", $time, e.b_x, got.b_x);
            errors++;
         end
         if (got.b_y !== e.b_y) begin
            $display("%0t: b_y expected %h actual %h", $time, e.b_y, got.b_y);
            errors++;
         end
         if (got.status !== e.status) begin
            $display("%0t: status expected %b actual %b", $time, e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   vce_req_if req_bus();
   vce_rsp_if rsp_bus();
   vce_csr_if csr_bus();

   verlet_constraint_engine_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   vertex_scoreboard sb = new();
   bit quiet_tail = 1'b0;
   bit long_hold = 1'b0;
   bit written[VERTICES];
   int written_list[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = '0;
      req_bus.vertex_a = '0;
      req_bus.vertex_b = '0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.rest_length = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
   end

   // monitors: accepted requests, register writes and responses
   always @(posedge clock) begin
      engine_rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note('{req_bus.mode, req_bus.vertex_a, req_bus.vertex_b,
                      req_bus.coord_x, req_bus.coord_y, req_bus.rest_length});
         if (csr_bus.valid && csr_bus.ready)
            sb.set_reg(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.a_x, rsp_bus.a_y, rsp_bus.b_x, rsp_bus.b_y, rsp_bus.status};
            sb.check(got);
         end
      end
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // offer one request and hold it until accepted
   task automatic send_req(engine_req_type r);
      if (r.mode == MODE_WRITE && !written[r.vertex_a]) begin
         written[r.vertex_a] = 1'b1;
         written_list = {written_list, int'(r.vertex_a)};
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= r.mode;
      req_bus.vertex_a <= r.vertex_a;
      req_bus.vertex_b <= r.vertex_b;
      req_bus.coord_x <= r.coord_x;
      req_bus.coord_y <= r.coord_y;
      req_bus.rest_length <= r.rest_length;
      do @(posedge clock); while (!req_bus.ready);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom();
      if (pick == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      if (pick == 2) return -$urandom_range(0, 32'h0100_0000);
      return $urandom_range(0, 32'h0320_0000);
   endfunction

   function automatic engine_req_type rand_req();
      engine_req_type r;
      int pick;
      r.vertex_b = $urandom();
      r.coord_x = $urandom();
      r.coord_y = $urandom();
      r.rest_length = $urandom();
      pick = $urandom_range(0, 99);
      if (written_list.size() < 2 || pick < 20) begin
         r.mode = MODE_WRITE;
         r.vertex_a = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 15);
         r.coord_x = rand_coord();
         r.coord_y = rand_coord();
         return r;
      end
      r.vertex_a = written_list[$urandom_range(0, written_list.size() - 1)];
      if (pick < 40) r.mode = MODE_INTEGRATE;
      else if (pick < 55) r.mode = MODE_CLAMP;
      else if (pick < 85) begin
         r.mode = MODE_RELAX;
         r.vertex_b = written_list[$urandom_range(0, written_list.size() - 1)];
         if ($urandom_range(0, 4) != 0) r.rest_length = $urandom_range(0, 32'h00c8_0000);
      end else if (pick < 95) r.mode = MODE_READ;
      else r.mode = $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);
      return r;
   endfunction

   // register settings per phase, extremes included
   task automatic load_phase(int ph);
      case (ph)
         0: begin
            write_reg(CSR_GRAVITY_X, 32'd0);
            write_reg(CSR_GRAVITY_Y, 32'h0000_8000);
            write_reg(CSR_STEP_SQUARED, 32'd65536);
            write_reg(CSR_RIGHT_LIMIT, 32'd52428800);
            write_reg(CSR_BOTTOM_LIMIT, 32'd39321600);
            write_reg(CSR_LOW_LIMIT, 32'd72090);
         end
         1: begin
            write_reg(CSR_GRAVITY_X, 32'h7fffffff);
            write_reg(CSR_GRAVITY_Y, 32'h80000000);
            write_reg(CSR_STEP_SQUARED, 32'h7fffffff);
            write_reg(CSR_RIGHT_LIMIT, 32'h7fffffff);
            write_reg(CSR_BOTTOM_LIMIT, 32'h7fffffff);
            write_reg(CSR_LOW_LIMIT, 32'd0);
         end
         2: begin
            write_reg(CSR_GRAVITY_X, 32'h80000000);
            write_reg(CSR_GRAVITY_Y, 32'h7fffffff);
            write_reg(CSR_STEP_SQUARED, 32'd0);
            write_reg(CSR_RIGHT_LIMIT, 32'd0);
            write_reg(CSR_BOTTOM_LIMIT, 32'd0);
            write_reg(CSR_LOW_LIMIT, 32'h7fffffff);
         end
         3: begin
            // low limit above both upper limits
            write_reg(CSR_GRAVITY_X, -32'sd3000);
            write_reg(CSR_GRAVITY_Y, 32'd9000);
            write_reg(CSR_STEP_SQUARED, 32'd16384);
            write_reg(CSR_RIGHT_LIMIT, 32'd100000);
            write_reg(CSR_BOTTOM_LIMIT, 32'd200000);
            write_reg(CSR_LOW_LIMIT, 32'd300000);
         end
         default: begin
            write_reg(CSR_GRAVITY_X, $urandom());
            write_reg(CSR_GRAVITY_Y, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 70000));
            write_reg(CSR_STEP_SQUARED, $urandom() >> $urandom_range(1, 16));
            write_reg(CSR_RIGHT_LIMIT, $urandom() >> $urandom_range(1, 8));
            write_reg(CSR_BOTTOM_LIMIT, $urandom() >> $urandom_range(1, 8));
            write_reg(CSR_LOW_LIMIT, $urandom() >> $urandom_range(8, 24));
         end
      endcase
   endtask

   initial begin
      engine_req_type r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every mode, zero-length and wide edges
      load_phase(0);
      send_req('{MODE_WRITE, 8'd0, 8'hff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff});
      send_req('{MODE_WRITE, 8'd1, 8'h00, 32'h80000000, 32'h80000000, 31'd0});
      send_req('{MODE_WRITE, 8'd255, 8'h00, 32'h0010_0000, 32'h0020_0000, 31'd0});
      send_req('{MODE_WRITE, 8'd2, 8'h5a, 32'h0010_0000, 32'h0020_0000, 31'd0});
      send_req('{MODE_READ, 8'd0, 8'h00, 32'hffffffff, 32'hffffffff, 31'h7fffffff});
      send_req('{MODE_RELAX, 8'd0, 8'd1, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_RELAX, 8'd1, 8'd0, 32'd0, 32'd0, 31'h7fffffff});
      send_req('{MODE_RELAX, 8'd255, 8'd255, 32'd0, 32'd0, 31'd65536});
      send_req('{MODE_RELAX, 8'd255, 8'd2, 32'd0, 32'd0, 31'd65536});
      send_req('{MODE_RELAX, 8'd2, 8'd1, 32'd0, 32'd0, 31'h0032_0000});
      send_req('{MODE_INTEGRATE, 8'd0, 8'h00, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_INTEGRATE, 8'd1, 8'h00, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_INTEGRATE, 8'd2, 8'h00, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_CLAMP, 8'd0, 8'h00, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_CLAMP, 8'd1, 8'h00, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_SPARE_LO, 8'd2, 8'hff, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_SPARE_MID, 8'd255, 8'h00, 32'd0, 32'd0, 31'd0});
      send_req('{MODE_SPARE_HI, 8'd1, 8'h00, 32'd0, 32'd0, 31'd0});

      // random phases, sender pauses for an empty pipeline between them
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         load_phase(ph);
         if (ph == 2) long_hold = 1'b1;
         if (ph == PHASES - 1) quiet_tail = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = rand_req();
            send_req(r);
         end
      end

      wait_idle();
      $display("Checked %0d responses over %0d register phases; %0d edge relaxations, %0d skipped",
               sb.checked, PHASES + 1, sb.relaxed, sb.skipped);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #30000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
